>>> src/srmas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmas_pkg
// Shared widths, codes and item types of the sparse row merge add/sub unit.
// ----------------------------------------------------------------------------
package srmas_pkg;

  localparam int COL_W = 16;
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ERR_W = 2;

  localparam int MAX_ROW_ENTRIES_DEF = 32;
  localparam int COLUMN_BITS_DEF     = 16;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // input operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  // load error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ORDER    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd3;

  // configuration register indexes
  localparam logic CFG_SUBTRACT_MODE = 1'b0;
  localparam logic CFG_MATRIX_DIM    = 1'b1;

  localparam logic [COL_W-1:0] MATRIX_DIM_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    range_err;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    empty_row;
    logic                    saturated;
    logic [ERR_W-1:0]        load_error;
  } out_item_t;

endpackage

>>> src/sparse_row_merge_add_sub_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_merge_add_sub_unit
// Merges two sparse rows of signed Q16.16 entries by addition or subtraction.
// ----------------------------------------------------------------------------
// Load items (row A or row B, ascending columns) are range-checked on entry
// and queued in a four-deep command queue; while no merge is in progress, the
// executor stores one load per cycle into its row RAM. A merge command
// starts in the cycle after it reaches the executor, then takes one step per
// distinct column present in either row (both row RAMs are read once per
// cycle) plus one closing step. Results pass through a two-deep output
// queue; the walk pauses while it is full. Zero results are dropped, and a
// merge with no nonzero result gives a single item with empty_row and last
// set. Configuration writes are taken every cycle and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module sparse_row_merge_add_sub_unit #(
  parameter int MAX_ROW_ENTRIES = srmas_pkg::MAX_ROW_ENTRIES_DEF,
  parameter int COLUMN_BITS     = srmas_pkg::COLUMN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [srmas_pkg::OP_W-1:0]         in_operation,
  input  logic [srmas_pkg::COL_W-1:0]        in_column,
  input  logic signed [srmas_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [srmas_pkg::COL_W-1:0]        out_column,
  output logic signed [srmas_pkg::VAL_W-1:0] out_value,
  output logic                               out_last,
  output logic                               out_empty_row,
  output logic                               out_saturated,
  output logic [srmas_pkg::ERR_W-1:0]        out_load_error,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [srmas_pkg::COL_W-1:0]        cfg_data
);
  import srmas_pkg::*;

  logic             subtract_mode_r, subtract_mode_nxt;
  logic [COL_W-1:0] matrix_dim_r, matrix_dim_nxt;

  logic             front_vld, cmd_full, cmd_empty, cmd_pop;
  cmd_t             front_cmd, back_cmd;
  logic             out_full, out_push;
  out_item_t        back_item, head_item;
  logic [$bits(cmd_t)-1:0]      cmd_dout;
  logic [$bits(out_item_t)-1:0] out_dout;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    subtract_mode_nxt = subtract_mode_r;
    matrix_dim_nxt    = matrix_dim_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SUBTRACT_MODE: subtract_mode_nxt = cfg_data[0];
        CFG_MATRIX_DIM:    matrix_dim_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subtract_mode_r <= 1'b0;
      matrix_dim_r    <= MATRIX_DIM_RST;
    end else begin
      subtract_mode_r <= subtract_mode_nxt;
      matrix_dim_r    <= matrix_dim_nxt;
    end
  end

  srmas_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
    .in_operation (in_operation),
    .in_column    (in_column),
    .in_value     (in_value),
    .matrix_dim   (matrix_dim_r),
    .cmd_vld      (front_vld),
    .cmd          (front_cmd)
  );

  assign in_full = cmd_full;

  srmas_fifo #(.W($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && front_vld),
    .din   (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_dout);

  srmas_back #(
    .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES),
    .COLUMN_BITS     (COLUMN_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .subtract_mode (subtract_mode_r),
    .cmd_empty     (cmd_empty),
    .cmd           (back_cmd),
    .cmd_pop       (cmd_pop),
    .out_full      (out_full),
    .out_push      (out_push),
    .out_item      (back_item)
  );

  srmas_fifo #(.W($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .din   (back_item),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty)
  );

  assign head_item      = out_item_t'(out_dout);
  assign out_column     = head_item.column;
  assign out_value      = head_item.value;
  assign out_last       = head_item.last;
  assign out_empty_row  = head_item.empty_row;
  assign out_saturated  = head_item.saturated;
  assign out_load_error = head_item.load_error;

  // the executor never offers an item the output queue cannot take
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_full |-> !out_push)
    else $error("result item pushed into full output queue");

  a_empty_row_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_empty_row) |->
      (out_last && out_column == '0 && out_value == '0 && !out_saturated))
    else $error("malformed empty-row item");

  a_nonzero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_empty_row) |-> (out_value != '0 && out_column != '0))
    else $error("zero result item emitted");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output queue not empty after reset");

endmodule

>>> src/srmas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmas_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module srmas_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/srmas_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmas_fifo
// Small register FIFO; the head item is visible while empty is low.
// ----------------------------------------------------------------------------
module srmas_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> src/srmas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmas_front
// Decodes incoming items into commands and range-checks load columns.
// ----------------------------------------------------------------------------
module srmas_front #(
  parameter int COLUMN_BITS = 16
) (
  input  logic [srmas_pkg::OP_W-1:0]         in_operation,
  input  logic [srmas_pkg::COL_W-1:0]        in_column,
  input  logic signed [srmas_pkg::VAL_W-1:0] in_value,
  input  logic [srmas_pkg::COL_W-1:0]        matrix_dim,
  output logic                               cmd_vld,
  output srmas_pkg::cmd_t                    cmd
);
  import srmas_pkg::*;

  localparam int CW = (COLUMN_BITS < COL_W) ? COLUMN_BITS : COL_W;
  localparam logic [COL_W-1:0] COL_MASK = {COL_W{1'b1}} >> (COL_W - CW);

  logic [COL_W-1:0] col_m;

  assign col_m = in_column & COL_MASK;

  always_comb begin
    cmd_vld       = 1'b1;
    cmd.kind      = CMD_MERGE;
    cmd.column    = col_m;
    cmd.value     = in_value;
    cmd.range_err = (col_m == '0) || (col_m > matrix_dim);
    unique case (in_operation)
      OP_LOAD_A: cmd.kind = CMD_LOAD_A;
      OP_LOAD_B: cmd.kind = CMD_LOAD_B;
      OP_MERGE:  cmd.kind = CMD_MERGE;
      default:   cmd_vld  = 1'b0;   // unused code, item is dropped
    endcase
  end

endmodule

>>> src/srmas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmas_back
// Executes commands: stores row entries with load checks, walks both rows on
// a merge and emits the merged items.
// ----------------------------------------------------------------------------
module srmas_back #(
  parameter int MAX_ROW_ENTRIES = 32,
  parameter int COLUMN_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   subtract_mode,
  input  logic                   cmd_empty,
  input  srmas_pkg::cmd_t        cmd,
  output logic                   cmd_pop,
  input  logic                   out_full,
  output logic                   out_push,
  output srmas_pkg::out_item_t   out_item
);
  import srmas_pkg::*;

  localparam int CW  = (COLUMN_BITS < COL_W) ? COLUMN_BITS : COL_W;
  localparam int IW  = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;
  localparam int CNW = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int DW  = CW + VAL_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNW-1:0]          cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [COL_W-1:0]        last_a_r, last_a_nxt, last_b_r, last_b_nxt;
  logic [ERR_W-1:0]        err_r, err_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [COL_W-1:0]        pend_col_r, pend_col_nxt;
  logic signed [VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic                    pend_sat_r, pend_sat_nxt;

  logic                    we_a, we_b;
  logic [DW-1:0]           wdata, rd_a, rd_b;
  logic [CNW-1:0]          ld_n;
  logic [COL_W-1:0]        ld_last;
  logic [ERR_W-1:0]        ld_err;

  logic                    a_has, b_has, take_a, take_b;
  logic [COL_W-1:0]        ca, cb, res_col;
  logic signed [VAL_W:0]   op_a, op_b, sum;
  logic signed [VAL_W-1:0] res_val;
  logic                    res_sat;

  assign wdata = {cmd.column[CW-1:0], cmd.value};

  srmas_ram #(.WIDTH(DW), .DEPTH(MAX_ROW_ENTRIES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[IW-1:0]),
    .wdata (wdata),
    .raddr (i_nxt[IW-1:0]),
    .rdata (rd_a)
  );

  srmas_ram #(.WIDTH(DW), .DEPTH(MAX_ROW_ENTRIES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[IW-1:0]),
    .wdata (wdata),
    .raddr (j_nxt[IW-1:0]),
    .rdata (rd_b)
  );

  // load checks: range beats overflow, overflow beats order
  always_comb begin
    ld_n    = (cmd.kind == CMD_LOAD_A) ? cnt_a_r : cnt_b_r;
    ld_last = (cmd.kind == CMD_LOAD_A) ? last_a_r : last_b_r;
    if (cmd.range_err) begin
      ld_err = ERR_RANGE;
    end else if (ld_n >= CNW'(MAX_ROW_ENTRIES)) begin
      ld_err = ERR_OVERFLOW;
    end else if (ld_n != '0 && cmd.column <= ld_last) begin
      ld_err = ERR_ORDER;
    end else begin
      ld_err = ERR_NONE;
    end
  end

  // one merge step on the entries at i_r / j_r
  always_comb begin
    a_has = (i_r < cnt_a_r);
    b_has = (j_r < cnt_b_r);
    ca    = COL_W'(rd_a[DW-1:VAL_W]);
    cb    = COL_W'(rd_b[DW-1:VAL_W]);
    if (a_has && b_has) begin
      take_a = (ca <= cb);
      take_b = (cb <= ca);
    end else begin
      take_a = a_has;
      take_b = !a_has;
    end
    op_a    = take_a ? {rd_a[VAL_W-1], rd_a[VAL_W-1:0]} : '0;
    op_b    = take_b ? {rd_b[VAL_W-1], rd_b[VAL_W-1:0]} : '0;
    sum     = subtract_mode ? (op_a - op_b) : (op_a + op_b);
    res_sat = (sum[VAL_W] != sum[VAL_W-1]);
    if (res_sat) begin
      res_val = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res_val = sum[VAL_W-1:0];
    end
    res_col = take_a ? ca : cb;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    last_a_nxt   = last_a_r;
    last_b_nxt   = last_b_r;
    err_nxt      = err_r;
    pend_vld_nxt = pend_vld_r;
    pend_col_nxt = pend_col_r;
    pend_val_nxt = pend_val_r;
    pend_sat_nxt = pend_sat_r;
    cmd_pop      = 1'b0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    out_push     = 1'b0;
    out_item.column     = pend_col_r;
    out_item.value      = pend_val_r;
    out_item.last       = 1'b0;
    out_item.empty_row  = 1'b0;
    out_item.saturated  = pend_sat_r;
    out_item.load_error = err_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_LOAD_A, CMD_LOAD_B: begin
              if (ld_err != ERR_NONE) begin
                if (err_r == ERR_NONE) begin
                  err_nxt = ld_err;
                end
              end else if (cmd.kind == CMD_LOAD_A) begin
                we_a       = 1'b1;
                cnt_a_nxt  = cnt_a_r + CNW'(1);
                last_a_nxt = cmd.column;
              end else begin
                we_b       = 1'b1;
                cnt_b_nxt  = cnt_b_r + CNW'(1);
                last_b_nxt = cmd.column;
              end
            end
            CMD_MERGE: state_nxt = ST_WALK;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!out_full) begin
          if (a_has || b_has) begin
            i_nxt = i_r + CNW'(take_a);
            j_nxt = j_r + CNW'(take_b);
            // hold one item back so the final one can carry last
            if (res_val != '0) begin
              out_push     = pend_vld_r;
              pend_vld_nxt = 1'b1;
              pend_col_nxt = res_col;
              pend_val_nxt = res_val;
              pend_sat_nxt = res_sat;
            end
          end else begin
            out_push      = 1'b1;
            out_item.last = 1'b1;
            if (!pend_vld_r) begin
              out_item.column    = '0;
              out_item.value     = '0;
              out_item.saturated = 1'b0;
              out_item.empty_row = 1'b1;
            end
            cnt_a_nxt    = '0;
            cnt_b_nxt    = '0;
            i_nxt        = '0;
            j_nxt        = '0;
            err_nxt      = ERR_NONE;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      i_r        <= '0;
      j_r        <= '0;
      err_r      <= ERR_NONE;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      err_r      <= err_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    last_a_r   <= last_a_nxt;
    last_b_r   <= last_b_nxt;
    pend_col_r <= pend_col_nxt;
    pend_val_r <= pend_val_nxt;
    pend_sat_r <= pend_sat_nxt;
  end

endmodule

>>> sim/sparse_row_merge_add_sub_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_merge_add_sub_unit_tb
// Self-checking testbench for the sparse row merge add/sub unit.
// ----------------------------------------------------------------------------
// Loads sparse rows A and B, issues merges and checks every emitted item
// against an in-bench row merger that tracks both rows, the sticky load
// error and the configuration. Directed cases cover value and column
// extremes, cancellation, saturation, load errors and their priority, the
// unused operation and the dimension extremes. Random rows follow, mostly
// well formed with shared columns, with full rows and stray loads mixed in.
// Both handshakes idle at random, with a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module sparse_row_merge_add_sub_unit_tb;
  import srmas_pkg::*;

  localparam int ROW_CAP         = MAX_ROW_ENTRIES_DEF;
  localparam int ROW_A           = 0;
  localparam int ROW_B           = 1;
  localparam int RANDOM_ITEMS    = 270;
  localparam int SETTLE_CYCLES   = 24;
  localparam int QUIET_LIMIT     = 3000;
  localparam int IDLE_PCT        = 15;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -Q_MAX - 64'sd1;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  logic [OP_W-1:0]         in_operation = OP_LOAD_A;
  logic [COL_W-1:0]        in_column = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic [COL_W-1:0]        out_column;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    out_empty_row;
  logic                    out_saturated;
  logic [ERR_W-1:0]        out_load_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = CFG_SUBTRACT_MODE;
  logic [COL_W-1:0]        cfg_data = '0;

  sparse_row_merge_add_sub_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_column     (in_column),
    .in_value      (in_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_column    (out_column),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_empty_row (out_empty_row),
    .out_saturated (out_saturated),
    .out_load_error(out_load_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // merger state, mirrors the block
  logic [COL_W-1:0]        row_col [2][ROW_CAP];
  logic signed [VAL_W-1:0] row_val [2][ROW_CAP];
  int                      row_cnt [2] = '{0, 0};
  logic [ERR_W-1:0]        sticky_err = ERR_NONE;
  logic                    sub_mode = 1'b0;
  logic [COL_W-1:0]        dim_q = MATRIX_DIM_RST;

  out_item_t merged_q[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int send_idle_pct = IDLE_PCT;
  int pop_idle_pct = IDLE_PCT;
  int quiet_cycles = 0;

  function automatic void apply_load(input int r, input logic [COL_W-1:0] col,
                                     input logic signed [VAL_W-1:0] val);
    logic [ERR_W-1:0] err;
    err = ERR_NONE;
    if (col == '0 || col > dim_q) err = ERR_RANGE;
    else if (row_cnt[r] >= ROW_CAP) err = ERR_OVERFLOW;
    else if (row_cnt[r] > 0 && col <= row_col[r][row_cnt[r]-1]) err = ERR_ORDER;
    if (err != ERR_NONE) begin
      if (sticky_err == ERR_NONE) sticky_err = err;
    end else begin
      row_col[r][row_cnt[r]] = col;
      row_val[r][row_cnt[r]] = val;
      row_cnt[r]++;
    end
  endfunction

  function automatic void apply_merge();
    int        i;
    int        j;
    longint    b;
    longint    sum;
    bit        sat;
    out_item_t item;
    out_item_t row_out[$];
    i = 0;
    j = 0;
    while (i < row_cnt[ROW_A] || j < row_cnt[ROW_B]) begin
      if (i < row_cnt[ROW_A] && j < row_cnt[ROW_B] &&
          row_col[ROW_A][i] == row_col[ROW_B][j]) begin
        item.column = row_col[ROW_A][i];
        b = row_val[ROW_B][j];
        sum = row_val[ROW_A][i];
        sum = sub_mode ? sum - b : sum + b;
        i++;
        j++;
      end else if (j >= row_cnt[ROW_B] ||
                   (i < row_cnt[ROW_A] && row_col[ROW_A][i] < row_col[ROW_B][j])) begin
        item.column = row_col[ROW_A][i];
        sum = row_val[ROW_A][i];
        i++;
      end else begin
        item.column = row_col[ROW_B][j];
        b = row_val[ROW_B][j];
        sum = sub_mode ? -b : b;
        j++;
      end
      sat = 1'b0;
      if (sum > Q_MAX) begin
        sum = Q_MAX;
        sat = 1'b1;
      end else if (sum < Q_MIN) begin
        sum = Q_MIN;
        sat = 1'b1;
      end
      if (sum != 0) begin
        item.value      = sum[VAL_W-1:0];
        item.last       = 1'b0;
        item.empty_row  = 1'b0;
        item.saturated  = sat;
        item.load_error = sticky_err;
        row_out.push_back(item);
      end
    end
    if (row_out.size() == 0) begin
      item = '0;
      item.empty_row  = 1'b1;
      item.load_error = sticky_err;
      row_out.push_back(item);
    end
    row_out[row_out.size()-1].last = 1'b1;
    foreach (row_out[k]) merged_q.push_back(row_out[k]);
    row_cnt[ROW_A] = 0;
    row_cnt[ROW_B] = 0;
    sticky_err = ERR_NONE;
  endfunction

  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [COL_W-1:0] col,
                                       input logic signed [VAL_W-1:0] val);
    case (op)
      OP_LOAD_A: apply_load(ROW_A, col, val);
      OP_LOAD_B: apply_load(ROW_B, col, val);
      OP_MERGE:  apply_merge();
      default:   ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // in_push is left high after acceptance; whoever comes next decides
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_operation <= op;
    in_column    <= col;
    in_value     <= val;
    do @(posedge clk); while (in_full);
    predict_item(op, col, val);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_settled();
    in_push <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    // trailing loads may still sit in the command queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic sub, input logic [COL_W-1:0] dim);
    wait_settled();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SUBTRACT_MODE;
    cfg_data  <= {{(COL_W-1){1'b0}}, sub};
    do @(posedge clk); while (!cfg_ready);
    sub_mode = sub;
    cfg_index <= CFG_MATRIX_DIM;
    cfg_data  <= dim;
    do @(posedge clk); while (!cfg_ready);
    dim_q = dim;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    int small_v;
    small_v = int'($urandom_range(131072)) - 65536;
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return small_v;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_dimension();
    case ($urandom_range(3))
      0:       return '1;
      1:       return COL_W'($urandom_range(65535, 1));
      2:       return COL_W'($urandom_range(300, 20));
      default: return COL_W'($urandom_range(8, 1));
    endcase
  endfunction

  // One pair of rows in ascending order, interleaved at random, then a merge.
  // A full pair fills both rows and ends with one faulty load.
  task automatic send_row_pair(input bit full_rows);
    logic [COL_W-1:0]        a_cols[$];
    logic [COL_W-1:0]        b_cols[$];
    logic signed [VAL_W-1:0] a_vals[$];
    logic signed [VAL_W-1:0] b_vals[$];
    logic signed [VAL_W-1:0] va;
    logic signed [VAL_W-1:0] vb;
    logic [OP_W-1:0]         stray_op;
    logic [COL_W-1:0]        stray_col;
    logic signed [VAL_W-1:0] stray_val;
    int                      n;
    int                      step_max;
    int                      cur;
    int                      pick;
    if (full_rows) n = 2 * ROW_CAP;
    else if ($urandom_range(9) == 0) n = $urandom_range(40, 12);
    else n = $urandom_range(10);
    if (full_rows || $urandom_range(1) == 1) step_max = 3;
    else step_max = int'(dim_q) / (n + 1) + 1;
    cur = 0;
    for (int k = 0; k < n; k++) begin
      cur += $urandom_range(step_max, 1);
      if (cur > int'(dim_q)) break;
      if (!full_rows) pick = $urandom_range(2);
      else if (a_cols.size() == ROW_CAP) pick = 1;
      else if (b_cols.size() == ROW_CAP) pick = 0;
      else pick = $urandom_range(1);
      va = rand_value();
      case ($urandom_range(3))
        0:       vb = va;
        1:       vb = -va;
        2:       vb = rand_value();
        default: vb = $urandom();
      endcase
      if (pick != 1) begin
        a_cols.push_back(COL_W'(cur));
        a_vals.push_back(va);
      end
      if (pick != 0) begin
        b_cols.push_back(COL_W'(cur));
        b_vals.push_back(vb);
      end
    end
    while (a_cols.size() + b_cols.size() != 0) begin
      if (!full_rows && $urandom_range(15) == 0) begin
        stray_op  = OP_W'($urandom_range(3));
        stray_col = COL_W'($urandom());
        stray_val = $urandom();
        send_item(stray_op, stray_col, stray_val);
      end
      if (b_cols.size() == 0 || (a_cols.size() != 0 && $urandom_range(1) == 0))
        send_item(OP_LOAD_A, a_cols.pop_front(), a_vals.pop_front());
      else
        send_item(OP_LOAD_B, b_cols.pop_front(), b_vals.pop_front());
    end
    if (full_rows) begin
      case ($urandom_range(2))
        0:       send_item(OP_LOAD_A, '0, rand_value());    // range beats overflow
        1:       send_item(OP_LOAD_A, row_col[ROW_A][row_cnt[ROW_A]-1], rand_value());
        default: send_item(OP_LOAD_B, '1, rand_value());
      endcase
    end
    stray_col = COL_W'($urandom());
    stray_val = $urandom();
    send_item(OP_MERGE, stray_col, stray_val);
  endtask

  task automatic test_add_basics();
    send_item(OP_MERGE, '0, '0);                 // nothing loaded
    send_item(OP_LOAD_A, 16'd1, 32'sh7FFF_FFFF);
    send_item(OP_LOAD_B, 16'd1, 32'sd1);         // clamps high
    send_item(OP_LOAD_B, 16'd2, -32'sd7);
    send_item(OP_LOAD_A, 16'd5, '0);             // zero entry, dropped on merge
    send_item(OP_LOAD_A, 16'd9, 32'sd3);
    send_item(OP_LOAD_B, 16'd9, -32'sd3);        // cancels
    send_item(OP_LOAD_A, 16'hFFFF, 32'sh8000_0000);
    send_item(OP_LOAD_B, 16'hFFFF, -32'sd1);     // clamps low
    send_item(OP_MERGE, 16'hFFFF, 32'shFFFF_FFFF);
  endtask

  task automatic test_load_errors();
    send_item(OP_LOAD_A, '0, 32'sd4);
    send_item(OP_LOAD_A, 16'd10, 32'sd4);
    send_item(OP_LOAD_A, 16'd10, 32'sd8);        // duplicate; first error sticks
    send_item(OP_UNUSED, 16'd3, 32'sd5);
    send_item(OP_LOAD_B, 16'd20, 32'sd6);
    send_item(OP_MERGE, '0, '0);
    send_item(OP_LOAD_B, 16'd20, 32'sd1);
    send_item(OP_LOAD_B, 16'd19, 32'sd1);
    send_item(OP_LOAD_A, '0, 32'sd1);
    send_item(OP_MERGE, '0, '0);
  endtask

  task automatic test_subtract();
    configure(1'b1, 16'd100);
    send_item(OP_LOAD_A, 16'd3, 32'sd5);
    send_item(OP_LOAD_B, 16'd3, 32'sd5);
    send_item(OP_LOAD_A, 16'd50, 32'sh8000_0000);
    send_item(OP_LOAD_B, 16'd50, 32'sd1);
    send_item(OP_LOAD_B, 16'd60, 32'sh8000_0000); // negation clamps
    send_item(OP_LOAD_A, 16'd100, 32'sd7);
    send_item(OP_LOAD_B, 16'd100, 32'sd2);
    send_item(OP_LOAD_B, 16'd101, 32'sd2);
    send_item(OP_MERGE, '0, '0);
  endtask

  task automatic test_dimension_limits();
    configure(1'b0, 16'd1);
    send_item(OP_LOAD_A, 16'd1, 32'sd9);
    send_item(OP_LOAD_B, 16'd1, 32'sd4);
    send_item(OP_LOAD_A, 16'd2, 32'sd1);
    send_item(OP_MERGE, '0, '0);
    configure(1'b1, '0);                         // every column out of range
    send_item(OP_LOAD_B, 16'd1, 32'sd1);
    send_item(OP_MERGE, '0, '0);
  endtask

  task automatic test_random_rows();
    int goal;
    int phase;
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      if (phase % 10 == 5) configure(1'($urandom_range(1)), '1);
      else if (phase % 5 == 0) configure(1'($urandom_range(1)), pick_dimension());
      if (phase == 10) begin
        send_idle_pct = 0;
        pop_idle_pct  = 0;
      end else if (phase == 15) begin
        send_idle_pct = IDLE_PCT;
        pop_idle_pct  = IDLE_PCT;
      end
      if (phase == 12) wait_settled();
      send_row_pair(phase % 10 == 6);
      phase++;
    end
  endtask

  always @(posedge clk) out_pop <= ($urandom_range(99) >= pop_idle_pct);

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (merged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item column %0d value %0d",
                                  out_column, out_value));
      end else begin
        want = merged_q.pop_front();
        if (out_column !== want.column)
          report_mismatch($sformatf("column %0d, want %0d", out_column, want.column));
        if (out_value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d (column %0d)",
                                    out_value, want.value, want.column));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (column %0d)",
                                    out_last, want.last, want.column));
        if (out_empty_row !== want.empty_row)
          report_mismatch($sformatf("empty_row %0b, want %0b",
                                    out_empty_row, want.empty_row));
        if (out_saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, want %0b (column %0d)",
                                    out_saturated, want.saturated, want.column));
        if (out_load_error !== want.load_error)
          report_mismatch($sformatf("load_error %0d, want %0d",
                                    out_load_error, want.load_error));
      end
    end
  end

  // stall watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_add_basics();
    test_load_errors();
    test_subtract();
    test_dimension_limits();
    test_random_rows();
    wait_settled();
    if (merged_q.size() != 0) report_mismatch("items still missing at end of run");
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
src/srmas_pkg.sv
src/srmas_ram.sv
src/srmas_fifo.sv
src/srmas_front.sv
src/srmas_back.sv
src/sparse_row_merge_add_sub_unit.sv
sim/sparse_row_merge_add_sub_unit_tb.sv
